FILE: hdl/lkvc_pkg.sv
`timescale 1ns / 1ps
// Types and constants shared by the LRU key/value cache.
// No dependencies; compiled before all other files.
package lkvc_pkg;

   localparam int CAP_W = 5;
   localparam logic [CAP_W-1:0] CAPACITY_RESET = 5'd16;

   localparam logic REQ_GET = 1'b0;
   localparam logic REQ_PUT = 1'b1;

   localparam logic signed [31:0] READ_MISS = -32'sd1;

   typedef struct packed {
      logic               req_type;
      logic signed [31:0] key;
      logic signed [31:0] value;
   } req_payload_type;

   typedef struct packed {
      logic               hit;
      logic signed [31:0] read_value;
      logic               evicted;
      logic signed [31:0] evicted_key;
   } rsp_payload_type;

   typedef logic [CAP_W-1:0] csr_payload_type;

endpackage

FILE: hdl/lkvc_stream_if.sv
`timescale 1ns / 1ps
// Valid/ready channel carrying one payload per transfer.
// The payload type is a parameter; the cache uses types from lkvc_pkg.
interface lkvc_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

FILE: hdl/lru_key_value_cache.sv
`timescale 1ns / 1ps
// Top level of the fully associative LRU key/value cache.
// Depends on lkvc_pkg and lkvc_stream_if.

// The cache takes one get or put request per cycle and returns one response for
// each, registered, in the cycle after the request transfer at the earliest. The key
// compare across all entries, the recency rank update and the state write all
// complete in the cycle of the request transfer, so a request may follow in the
// next cycle and sees the updated contents. A request is taken whenever the
// response register is empty or is being emptied in the same cycle. Capacity
// is written through the csr channel, which is always ready; write it only
// while no request is outstanding.
module lru_key_value_cache #(
   parameter int ENTRIES = 16
) (
   input logic               clock,
   input logic               reset,
   lkvc_stream_if.sink       req,
   lkvc_stream_if.source     rsp,
   lkvc_stream_if.sink       csr
);
   import lkvc_pkg::*;

   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W = $clog2(ENTRIES + 1);
   localparam int CMP_W = ((CNT_W > CAP_W) ? CNT_W : CAP_W) + 1;

   logic [ENTRIES-1:0]     valid_ff, valid_in;
   logic signed [31:0]     key_ff [ENTRIES];
   logic signed [31:0]     key_in [ENTRIES];
   logic signed [31:0]     value_ff [ENTRIES];
   logic signed [31:0]     value_in [ENTRIES];
   logic [IDX_W-1:0]       rank_ff [ENTRIES];
   logic [IDX_W-1:0]       rank_in [ENTRIES];
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [CAP_W-1:0]       cap_ff, cap_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_payload_type        rsp_data_ff, rsp_data_in;

   req_payload_type        rq;
   logic                   accept;
   logic [ENTRIES-1:0]     match;
   logic                   hit_any;
   logic [IDX_W-1:0]       hit_idx;
   logic                   free_any;
   logic [IDX_W-1:0]       free_idx;
   logic [IDX_W-1:0]       victim_idx;
   logic [IDX_W-1:0]       oldest_rank;
   logic [CMP_W-1:0]       cap_eff;
   logic [CMP_W-1:0]       count_ext;
   logic                   full;
   logic                   do_promote;
   logic                   do_insert;
   logic [IDX_W-1:0]       tgt_idx;
   logic [IDX_W-1:0]       tgt_rank;

   assign rq       = req.payload;
   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign accept   = req.valid && req.ready;
   assign csr.ready = 1'b1;

   assign rsp.valid   = rsp_valid_ff;
   assign rsp.payload = rsp_data_ff;

   always_comb begin
      hit_any    = 1'b0;
      hit_idx    = '0;
      free_any   = 1'b0;
      free_idx   = '0;
      victim_idx = '0;
      oldest_rank = IDX_W'(count_ff - CNT_W'(1));
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         match[i] = valid_ff[i] && (key_ff[i] == rq.key);
         if (match[i]) begin
            hit_any = 1'b1;
            hit_idx = IDX_W'(i);
         end
         if (!valid_ff[i]) begin
            free_any = 1'b1;
            free_idx = IDX_W'(i);
         end
         if (valid_ff[i] && rank_ff[i] == oldest_rank) begin
            victim_idx = IDX_W'(i);
         end
      end
   end

   always_comb begin
      cap_eff = CMP_W'(cap_ff);
      if (cap_eff == '0) begin
         cap_eff = CMP_W'(1);
      end
      if (cap_eff > CMP_W'(ENTRIES)) begin
         cap_eff = CMP_W'(ENTRIES);
      end
      count_ext = CMP_W'(count_ff);
      full      = count_ext >= cap_eff;
   end

   always_comb begin
      valid_in     = valid_ff;
      key_in       = key_ff;
      value_in     = value_ff;
      rank_in      = rank_ff;
      count_in     = count_ff;
      cap_in       = cap_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      do_promote   = 1'b0;
      do_insert    = 1'b0;
      tgt_idx      = hit_idx;
      tgt_rank     = rank_ff[hit_idx];

      if (csr.valid) begin
         cap_in = csr.payload;
      end

      if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end

      if (accept) begin
         rsp_valid_in            = 1'b1;
         rsp_data_in.hit         = hit_any;
         rsp_data_in.read_value  = '0;
         rsp_data_in.evicted     = 1'b0;
         rsp_data_in.evicted_key = '0;
         if (hit_any) begin
            do_promote = 1'b1;
            if (rq.req_type == REQ_PUT) begin
               value_in[hit_idx] = rq.value;
            end else begin
               rsp_data_in.read_value = value_ff[hit_idx];
            end
         end else if (rq.req_type == REQ_GET) begin
            rsp_data_in.read_value = READ_MISS;
         end else if (full) begin
            do_promote              = 1'b1;
            tgt_idx                 = victim_idx;
            tgt_rank                = oldest_rank;
            rsp_data_in.evicted     = 1'b1;
            rsp_data_in.evicted_key = key_ff[victim_idx];
            key_in[victim_idx]      = rq.key;
            value_in[victim_idx]    = rq.value;
         end else if (free_any) begin
            do_insert          = 1'b1;
            tgt_idx            = free_idx;
            valid_in[free_idx] = 1'b1;
            key_in[free_idx]   = rq.key;
            value_in[free_idx] = rq.value;
            count_in           = count_ff + CNT_W'(1);
         end
      end

      for (int i = 0; i < ENTRIES; i++) begin
         if (IDX_W'(i) == tgt_idx) begin
            if (do_promote || do_insert) begin
               rank_in[i] = '0;
            end
         end else if (valid_ff[i]) begin
            if ((do_promote && rank_ff[i] < tgt_rank) || do_insert) begin
               rank_in[i] = rank_ff[i] + IDX_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         count_ff     <= '0;
         cap_ff       <= CAPACITY_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         count_ff     <= count_in;
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff      <= key_in;
      value_ff    <= value_in;
      rank_ff     <= rank_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

FILE: bench/lru_key_value_cache_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the LRU key/value cache (lru_key_value_cache).
// Depends on lkvc_pkg, lkvc_stream_if and the cache RTL; it needs no other file.
module lru_key_value_cache_tb;
   import lkvc_pkg::*;

   localparam int ENTRIES     = 16;
   localparam int CYCLE_LIMIT = 500000;

   logic clock = 1'b0;
   logic reset;

   lkvc_stream_if #(.payload_type(req_payload_type)) req_if ();
   lkvc_stream_if #(.payload_type(rsp_payload_type)) rsp_if ();
   lkvc_stream_if #(.payload_type(csr_payload_type)) csr_if ();

   lru_key_value_cache u_top (
      .clock (clock),
      .reset (reset),
      .req   (req_if),
      .rsp   (rsp_if),
      .csr   (csr_if)
   );

   always #5 clock = ~clock;

   req_payload_type    pending_requests[$];
   rsp_payload_type    expected_rsps[$];
   int unsigned        mismatch_count = 0;
   int unsigned        cycle_count    = 0;
   bit                 steady_stream  = 1'b0;

   csr_payload_type    capacity_setting = CAPACITY_RESET;
   logic               slot_valid[ENTRIES];
   logic signed [31:0] slot_key[ENTRIES];
   logic signed [31:0] slot_value[ENTRIES];
   logic [3:0]         slot_rank[ENTRIES];
   logic [4:0]         fill_count = '0;

   int req_gap  = 0;
   int req_calm = 0;
   int rsp_gap  = 0;
   int rsp_calm = 0;

   function automatic void make_most_recent(int idx);
      for (int i = 0; i < ENTRIES; i++) begin
         if (i != idx && slot_valid[i] && slot_rank[i] < slot_rank[idx]) begin
            slot_rank[i]++;
         end
      end
      slot_rank[idx] = '0;
   endfunction

   function automatic rsp_payload_type serve_request(req_payload_type r);
      rsp_payload_type res;
      logic [4:0]      cap;
      int              found;
      int              victim;
      int              slot;
      res    = '0;
      found  = -1;
      victim = -1;
      slot   = -1;
      cap    = capacity_setting;
      if (cap == 0) cap = 5'd1;
      if (cap > ENTRIES) cap = 5'(ENTRIES);
      for (int i = 0; i < ENTRIES; i++) begin
         if (found < 0 && slot_valid[i] && slot_key[i] == r.key) found = i;
      end
      if (found >= 0) begin
         res.hit = 1'b1;
         if (r.req_type == REQ_PUT) begin
            slot_value[found] = r.value;
         end else begin
            res.read_value = slot_value[found];
         end
         make_most_recent(found);
      end else if (r.req_type == REQ_GET) begin
         res.read_value = READ_MISS;
      end else if (fill_count >= cap) begin
         for (int i = 0; i < ENTRIES; i++) begin
            if (slot_valid[i] && (victim < 0 || slot_rank[i] > slot_rank[victim])) victim = i;
         end
         if (victim >= 0) begin
            res.evicted       = 1'b1;
            res.evicted_key   = slot_key[victim];
            slot_key[victim]   = r.key;
            slot_value[victim] = r.value;
            make_most_recent(victim);
         end
      end else begin
         for (int i = 0; i < ENTRIES; i++) begin
            if (slot < 0 && !slot_valid[i]) slot = i;
         end
         if (slot >= 0) begin
            for (int i = 0; i < ENTRIES; i++) begin
               if (slot_valid[i]) slot_rank[i]++;
            end
            slot_valid[slot] = 1'b1;
            slot_key[slot]   = r.key;
            slot_value[slot] = r.value;
            slot_rank[slot]  = '0;
            fill_count++;
         end
      end
      return res;
   endfunction

   function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $display("%0t ns: %s mismatch, expected %h, actual %h", $time, field, want, got);
         mismatch_count++;
      end
   endfunction

   function automatic logic signed [31:0] pick_word();
      logic signed [31:0] word;
      word = $urandom;
      if ($urandom_range(0, 7) == 0) begin
         case ($urandom_range(0, 3))
            0: word = 32'sh8000_0000;
            1: word = 32'sh7fff_ffff;
            2: word = 32'sh0;
            default: word = -32'sd1;
         endcase
      end
      return word;
   endfunction

   task automatic queue_request(logic kind, logic signed [31:0] key, logic signed [31:0] value);
      req_payload_type item;
      item.req_type = kind;
      item.key      = key;
      item.value    = value;
      pending_requests.push_back(item);
   endtask

   task automatic queue_random_phase(csr_payload_type setting, int count);
      logic signed [31:0] key_pool[$];
      int                 pool_size;
      logic signed [31:0] key;
      pool_size = (setting == 0) ? 1 : ((setting > ENTRIES) ? ENTRIES : int'(setting));
      pool_size += $urandom_range(1, 6);
      for (int i = 0; i < pool_size; i++) key_pool.push_back(pick_word());
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 99) < 85) begin
            key = key_pool[$urandom_range(0, pool_size - 1)];
         end else begin
            key = $urandom;
         end
         queue_request($urandom_range(0, 1) ? REQ_PUT : REQ_GET, key, pick_word());
      end
   endtask

   task automatic wait_until_drained();
      do @(posedge clock);
      while (pending_requests.size() != 0 || req_if.valid || expected_rsps.size() != 0);
   endtask

   task automatic write_capacity(csr_payload_type setting);
      @(posedge clock);
      csr_if.valid   <= 1'b1;
      csr_if.payload <= setting;
      do @(posedge clock);
      while (!csr_if.ready);
      csr_if.valid <= 1'b0;
   endtask

   // Request driver: holds an item until its transfer, with random bursts of idling.
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            expected_rsps.push_back(serve_request(req_if.payload));
         end
         if (!req_if.valid || req_if.ready) begin
            if (req_gap > 0) begin
               req_gap--;
               req_if.valid <= 1'b0;
            end else if (!steady_stream && req_calm == 0 && $urandom_range(0, 5) == 0) begin
               req_gap  = $urandom_range(1, 15) - 1;
               req_calm = $urandom_range(0, 40);
               req_if.valid <= 1'b0;
            end else begin
               if (req_calm > 0) req_calm--;
               if (pending_requests.size() != 0) begin
                  req_if.valid   <= 1'b1;
                  req_if.payload <= pending_requests.pop_front();
               end else begin
                  req_if.valid <= 1'b0;
               end
            end
         end
      end
   end

   // Response monitor: checks each transfer against the oldest expectation.
   always @(posedge clock) begin
      rsp_payload_type want;
      if (reset) begin
         rsp_if.ready <= 1'b1;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_rsps.size() == 0) begin
               $display("%0t ns: response transfer with no expectation waiting, actual %h",
                        $time, rsp_if.payload);
               mismatch_count++;
            end else begin
               want = expected_rsps.pop_front();
               check_field("hit", 32'(want.hit), 32'(rsp_if.payload.hit));
               check_field("read_value", want.read_value, rsp_if.payload.read_value);
               check_field("evicted", 32'(want.evicted), 32'(rsp_if.payload.evicted));
               check_field("evicted_key", want.evicted_key, rsp_if.payload.evicted_key);
            end
         end
         if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_if.ready <= 1'b0;
         end else if (!steady_stream && rsp_calm == 0 && $urandom_range(0, 5) == 0) begin
            rsp_gap  = $urandom_range(1, 15) - 1;
            rsp_calm = $urandom_range(0, 40);
            rsp_if.ready <= 1'b0;
         end else begin
            if (rsp_calm > 0) rsp_calm--;
            rsp_if.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && csr_if.valid && csr_if.ready) capacity_setting = csr_if.payload;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      csr_payload_type phase_settings[$];
      reset          = 1'b1;
      req_if.valid   = 1'b0;
      req_if.payload = '0;
      rsp_if.ready   = 1'b1;
      csr_if.valid   = 1'b0;
      csr_if.payload = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         slot_valid[i] = 1'b0;
         slot_key[i]   = '0;
         slot_value[i] = '0;
         slot_rank[i]  = '0;
      end
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Reset capacity: a miss on the empty store, extreme keys and values, an update.
      queue_request(REQ_GET, 32'sh0, $urandom);
      queue_request(REQ_PUT, 32'sh8000_0000, 32'sh7fff_ffff);
      queue_request(REQ_PUT, 32'sh7fff_ffff, 32'sh8000_0000);
      queue_request(REQ_PUT, 32'sh0, 32'sh0);
      queue_request(REQ_PUT, -32'sd1, -32'sd1);
      queue_request(REQ_GET, 32'sh8000_0000, $urandom);
      queue_request(REQ_GET, 32'sh7fff_ffff, $urandom);
      queue_request(REQ_GET, -32'sd1, $urandom);
      queue_request(REQ_PUT, 32'sh0, 32'sh1234_5678);
      queue_request(REQ_GET, 32'sh0, $urandom);
      queue_request(REQ_GET, 32'sd5, $urandom);
      wait_until_drained();

      // A capacity of zero acts as one, and the store already holds more than that.
      write_capacity(5'd0);
      queue_request(REQ_PUT, 32'sd100, 32'sd1);
      queue_request(REQ_GET, 32'sh8000_0000, $urandom);
      queue_request(REQ_PUT, 32'sd200, 32'sd2);
      queue_request(REQ_GET, 32'sd100, $urandom);
      queue_request(REQ_PUT, 32'sd300, 32'sd3);
      queue_request(REQ_PUT, 32'sd100, 32'sd7);
      wait_until_drained();

      write_capacity(5'd2);
      queue_request(REQ_PUT, 32'sd400, 32'sd4);
      queue_request(REQ_GET, 32'sd200, $urandom);
      queue_request(REQ_PUT, 32'sd500, 32'sd5);
      wait_until_drained();

      // A capacity above the entry count saturates.
      write_capacity(5'd31);
      queue_request(REQ_PUT, 32'sd600, 32'sd6);
      queue_request(REQ_PUT, 32'sd700, 32'sd7);
      queue_request(REQ_GET, 32'sd600, $urandom);
      queue_request(REQ_GET, -32'sd2, $urandom);
      wait_until_drained();

      phase_settings = '{5'd5, 5'd1, 5'd16, 5'd0, 5'd3, 5'd17, 5'd8,
                         csr_payload_type'($urandom_range(1, 16)), 5'd2, 5'd31, 5'd16};
      foreach (phase_settings[p]) begin
         if (p == phase_settings.size() - 1) steady_stream = 1'b1;
         write_capacity(phase_settings[p]);
         queue_random_phase(phase_settings[p], 180);
         wait_until_drained();
      end

      repeat (5) @(posedge clock);
      if (mismatch_count == 0 && expected_rsps.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
